// ===== sv/hrl_pkg.sv =====
// Shared types and constants for the hex record loader.
`default_nettype none

package hrl_pkg;

	localparam logic [7:0] CHAR_COLON = 8'd58;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;

	localparam logic [7:0] REC_TYPE_DATA = 8'h00;
	localparam logic [7:0] REC_TYPE_EXT  = 8'h04;

	typedef enum logic [2:0] {
		KIND_WRITE     = 3'd0,
		KIND_OK        = 3'd1,
		KIND_SUM_BAD   = 3'd2,
		KIND_DIGIT_BAD = 3'd3,
		KIND_TRUNC     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  wr_byte;
		logic [15:0] entry_point;
	} out_item_t;

endpackage

`default_nettype wire

// ===== sv/hrl_parser.sv =====
// Record parser: decoder state and the per-character update.
`default_nettype none

module hrl_parser
	import hrl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire logic      type4_as_data,
	output logic           res_valid,
	output out_item_t      res
);

	typedef enum logic [2:0] {
		IDX_COUNT  = 3'd0,
		IDX_ADDR_H = 3'd1,
		IDX_ADDR_L = 3'd2,
		IDX_TYPE   = 3'd3,
		IDX_DATA   = 3'd4,
		IDX_SUM    = 3'd5
	} byte_idx_t;

	logic        phase_q, phase_d;
	logic        nibble_pending_q, nibble_pending_d;
	logic [3:0]  high_nibble_q, high_nibble_d;
	byte_idx_t   byte_index_q, byte_index_d;
	logic [7:0]  data_count_q, data_count_d;
	logic [15:0] record_address_q, record_address_d;
	logic [7:0]  record_type_q, record_type_d;
	logic [7:0]  byte_offset_q, byte_offset_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic        digit_error_q, digit_error_d;
	logic [15:0] entry_address_q, entry_address_d;
	logic        entry_seen_q, entry_seen_d;

	logic [3:0]  nib;
	logic        nib_bad;
	logic [7:0]  byte_val;
	logic [7:0]  sum_next;
	logic [7:0]  offset_inc;
	logic        write_en;

	// ASCII hex digit decode; anything else is flagged and reads as zero
	always_comb begin
		nib     = 4'd0;
		nib_bad = 1'b0;
		if (item.character >= 8'd48 && item.character <= 8'd57) begin
			nib = 4'(item.character - 8'd48);
		end else if (item.character >= 8'd65 && item.character <= 8'd70) begin
			nib = 4'(item.character - 8'd55);
		end else if (item.character >= 8'd97 && item.character <= 8'd102) begin
			nib = 4'(item.character - 8'd87);
		end else begin
			nib_bad = 1'b1;
		end
	end

	assign byte_val   = {high_nibble_q, nib};
	assign sum_next   = running_sum_q + byte_val;
	assign offset_inc = byte_offset_q + 8'd1;
	assign write_en   = (record_type_q == REC_TYPE_DATA) ||
	                    ((record_type_q == REC_TYPE_EXT) && type4_as_data);

	always_comb begin
		phase_d          = phase_q;
		nibble_pending_d = nibble_pending_q;
		high_nibble_d    = high_nibble_q;
		byte_index_d     = byte_index_q;
		data_count_d     = data_count_q;
		record_address_d = record_address_q;
		record_type_d    = record_type_q;
		byte_offset_d    = byte_offset_q;
		running_sum_d    = running_sum_q;
		digit_error_d    = digit_error_q;
		entry_address_d  = entry_address_q;
		entry_seen_d     = entry_seen_q;
		res_valid        = 1'b0;
		res.kind         = KIND_WRITE;
		res.address      = record_address_q;
		res.wr_byte      = 8'd0;

		if (item.character == CHAR_LF || item.character == CHAR_CR) begin
			// line ends are dropped everywhere
		end else if (!phase_q) begin
			if (item.character == CHAR_COLON) begin
				phase_d          = 1'b1;
				nibble_pending_d = 1'b0;
				high_nibble_d    = 4'd0;
				byte_index_d     = IDX_COUNT;
				data_count_d     = 8'd0;
				record_address_d = 16'd0;
				record_type_d    = 8'd0;
				byte_offset_d    = 8'd0;
				running_sum_d    = 8'd0;
				digit_error_d    = 1'b0;
			end
		end else begin
			if (nib_bad) begin
				digit_error_d = 1'b1;
			end
			if (!nibble_pending_q) begin
				high_nibble_d    = nib;
				nibble_pending_d = 1'b1;
			end else begin
				nibble_pending_d = 1'b0;
				case (byte_index_q)
					IDX_COUNT: begin
						data_count_d  = byte_val;
						running_sum_d = sum_next;
						byte_index_d  = IDX_ADDR_H;
					end
					IDX_ADDR_H: begin
						record_address_d = {byte_val, 8'd0};
						running_sum_d    = sum_next;
						byte_index_d     = IDX_ADDR_L;
					end
					IDX_ADDR_L: begin
						record_address_d = {record_address_q[15:8], byte_val};
						running_sum_d    = sum_next;
						if (!entry_seen_q) begin
							entry_address_d = {record_address_q[15:8], byte_val};
							entry_seen_d    = 1'b1;
						end
						byte_index_d = IDX_TYPE;
					end
					IDX_TYPE: begin
						record_type_d = byte_val;
						running_sum_d = sum_next;
						byte_offset_d = 8'd0;
						byte_index_d  = (data_count_q != 8'd0) ? IDX_DATA : IDX_SUM;
					end
					IDX_DATA: begin
						running_sum_d = sum_next;
						if (write_en) begin
							res_valid   = 1'b1;
							res.kind    = KIND_WRITE;
							res.address = record_address_q + {8'd0, byte_offset_q};
							res.wr_byte = byte_val;
						end
						byte_offset_d = offset_inc;
						if (offset_inc == data_count_q) begin
							byte_index_d = IDX_SUM;
						end
					end
					default: begin
						res_valid   = 1'b1;
						res.address = record_address_q;
						if (digit_error_d) begin
							res.kind = KIND_DIGIT_BAD;
						end else if (sum_next == 8'd0) begin
							res.kind = KIND_OK;
						end else begin
							res.kind = KIND_SUM_BAD;
						end
						phase_d = 1'b0;
					end
				endcase
			end
		end

		// image ended inside a record: report it, any pending write is lost
		if (item.last_char && phase_d) begin
			res_valid   = 1'b1;
			res.kind    = KIND_TRUNC;
			res.address = record_address_d;
			res.wr_byte = 8'd0;
			phase_d     = 1'b0;
		end

		res.entry_point = entry_address_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= 1'b0;
			nibble_pending_q <= 1'b0;
			high_nibble_q    <= 4'd0;
			byte_index_q     <= IDX_COUNT;
			data_count_q     <= 8'd0;
			record_address_q <= 16'd0;
			record_type_q    <= 8'd0;
			byte_offset_q    <= 8'd0;
			running_sum_q    <= 8'd0;
			digit_error_q    <= 1'b0;
			entry_address_q  <= 16'd0;
			entry_seen_q     <= 1'b0;
		end else if (step) begin
			phase_q          <= phase_d;
			nibble_pending_q <= nibble_pending_d;
			high_nibble_q    <= high_nibble_d;
			byte_index_q     <= byte_index_d;
			data_count_q     <= data_count_d;
			record_address_q <= record_address_d;
			record_type_q    <= record_type_d;
			byte_offset_q    <= byte_offset_d;
			running_sum_q    <= running_sum_d;
			digit_error_q    <= digit_error_d;
			entry_address_q  <= entry_address_d;
			entry_seen_q     <= entry_seen_d;
		end
	end

	// a record-end result always leaves the parser outside a record
	a_close_exits: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind != KIND_WRITE |=> !phase_q)
		else $error("record closed but parser still inside record");

	// writes come only from data bytes
	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == KIND_WRITE |-> byte_index_q == IDX_DATA && phase_q)
		else $error("write issued outside data field");

	// entry point is latched once and never moves afterwards
	a_entry_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		entry_seen_q |=> entry_seen_q && $stable(entry_address_q))
		else $error("entry point changed after first record");

endmodule

`default_nettype wire

// ===== sv/hex_record_loader.sv =====
// Top level of the hex record loader: input register, parser, result register.
`default_nettype none

// Hex image loader. Feed the image one ASCII character per input transfer,
// with last_char set on the final one. Each character is taken into an input
// register and run through the record parser, and any result (memory write,
// record status or truncation report) lands in an output register. One
// character is accepted every cycle while the result side keeps up; the
// single parser state update per character sets this rate. The configuration
// channel writes type4_as_data (reset 1); it is always ready and should only
// be written while no characters are in flight.
module hex_record_loader
	import hrl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      res_valid;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      type4_as_data_q;

	// the parser steps when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type4_as_data_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			type4_as_data_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	hrl_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.type4_as_data (type4_as_data_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	// result register; characters without a result just empty it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
